[design/smou_pkg.sv]
package smou_pkg;

   localparam int unsigned STACK_DEPTH = 256;
   localparam int unsigned SP_W = $clog2(STACK_DEPTH);
   localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int unsigned WORD_W = 32;
   localparam int unsigned STEP_W = $clog2(WORD_W + 1);

   localparam logic [4:0] OP_NEG = 5'd1;
   localparam logic [4:0] OP_ADD = 5'd2;
   localparam logic [4:0] OP_SUB = 5'd3;
   localparam logic [4:0] OP_MUL = 5'd4;
   localparam logic [4:0] OP_DIV = 5'd5;
   localparam logic [4:0] OP_MOD = 5'd6;
   localparam logic [4:0] OP_EQ = 5'd7;
   localparam logic [4:0] OP_NE = 5'd8;
   localparam logic [4:0] OP_LT = 5'd9;
   localparam logic [4:0] OP_GE = 5'd10;
   localparam logic [4:0] OP_GT = 5'd11;
   localparam logic [4:0] OP_LE = 5'd12;
   localparam logic [4:0] OP_WRITE = 5'd13;
   localparam logic [4:0] OP_WRITELN = 5'd14;
   localparam logic [4:0] OP_READ = 5'd15;
   localparam logic [4:0] OP_READLN = 5'd16;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_UNDER = 3'd1;
   localparam logic [2:0] ST_SOVF = 3'd2;
   localparam logic [2:0] ST_AOVF = 3'd3;
   localparam logic [2:0] ST_DIV0 = 3'd4;
   localparam logic [2:0] ST_BADOP = 3'd5;

   // Control between the sequencer and the bit-serial arithmetic unit.
   typedef struct packed {
      logic start;
      logic is_mul;
   } ser_ctl_type;

   typedef struct packed {
      logic done;
   } ser_sts_type;

endpackage

[design/smou_serial_unit.sv]
// Bit-serial multiply and divide on 32-bit magnitudes. One bit of the
// operand shifts through per cycle; done rises with the last shift step.
module smou_serial_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  smou_pkg::ser_ctl_type        ctl,
   input  logic [smou_pkg::WORD_W-1:0]  a_mag,
   input  logic [smou_pkg::WORD_W-1:0]  b_mag,
   output smou_pkg::ser_sts_type        sts,
   output logic [2*smou_pkg::WORD_W-1:0] prod,
   output logic [smou_pkg::WORD_W-1:0]  quot,
   output logic [smou_pkg::WORD_W-1:0]  rem
);
   import smou_pkg::*;

   logic              busy_ff, busy_in;
   logic              mul_ff, mul_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0] b_ff, b_in;
   // Multiply: acc_ff holds the high half, sh_ff the multiplier then low half.
   // Divide: acc_ff holds the partial remainder, sh_ff the dividend then quotient.
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] sh_ff, sh_in;
   logic              done_ff, done_in;

   logic [WORD_W:0]   msum;
   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   rsh;

   always_comb begin
      msum  = {1'b0, acc_ff} + (sh_ff[0] ? {1'b0, b_ff} : '0);
      rsh   = {acc_ff, sh_ff[WORD_W-1]};
      trial = rsh - {1'b0, b_ff};
      busy_in = busy_ff;
      mul_in  = mul_ff;
      cnt_in  = cnt_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         busy_in = 1'b1;
         mul_in  = ctl.is_mul;
         cnt_in  = '0;
         b_in    = b_mag;
         acc_in  = '0;
         sh_in   = ctl.is_mul ? b_mag : a_mag;
         if (ctl.is_mul) b_in = a_mag;
      end else if (busy_ff) begin
         if (mul_ff) begin
            acc_in = msum[WORD_W:1];
            sh_in  = {msum[0], sh_ff[WORD_W-1:1]};
         end else if (!trial[WORD_W]) begin
            acc_in = trial[WORD_W-1:0];
            sh_in  = {sh_ff[WORD_W-2:0], 1'b1};
         end else begin
            acc_in = rsh[WORD_W-1:0];
            sh_in  = {sh_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         mul_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         mul_ff  <= mul_in;
      end
      b_ff   <= b_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
   end

   assign sts.done = done_ff;
   assign prod = {acc_ff, sh_ff};
   assign quot = sh_ff;
   assign rem  = acc_ff;

`ifndef NO_ASSERTIONS
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held two cycles");
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !ctl.start && cnt_ff == STEP_W'(WORD_W - 1)) |=> done_ff)
      else $error("last step did not finish");
`endif

endmodule

[design/stack_machine_operate_unit_core.sv]
// Channel   | Ports                                    | Direction
// request   | start, busy, req_opcode, req_string_flag,| in (busy out)
//           | req_read_value                           |
// response  | rsp_valid, rsp_status, rsp_print_*,      | out
//           | rsp_top_value, rsp_stack_count           |
//
// A request is taken at a rising edge where start is high and busy is low.
// Busy then stays high through the operand fetch of b and a, the execute
// cycle and the top-of-stack read, and the response shows up in the cycle
// after that read, with busy already low. Multiply, divide and modulo also
// wait in the bit-serial unit for its 32 shift steps and its done flag; a
// divide by zero or an underflow is caught before the serial unit starts.
// Reset empties the stack through the word count; memory contents are not
// cleared.
// The receiver cannot stall: each response is shown for one cycle with
// rsp_valid high.
module stack_machine_operate_unit_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [4:0]                    req_opcode,
   input  logic                          req_string_flag,
   input  logic signed [31:0]            req_read_value,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic                          rsp_print_valid,
   output logic signed [31:0]            rsp_print_value,
   output logic                          rsp_print_is_string,
   output logic                          rsp_print_newline,
   output logic signed [31:0]            rsp_top_value,
   output logic [8:0]                    rsp_stack_count
);
   import smou_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_RDB  = 6'b000010,
      S_RDA  = 6'b000100,
      S_EXEC = 6'b001000,
      S_SER  = 6'b010000,
      S_TOP  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [4:0]         op_ff, op_in;
   logic               sflag_ff, sflag_in;
   logic [WORD_W-1:0]  rval_ff, rval_in;
   logic [WORD_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [2:0]         st_ff, st_in;
   logic               pv_ff, pv_in;
   logic [WORD_W-1:0]  pval_ff, pval_in;
   logic               pstr_ff, pstr_in, pnl_ff, pnl_in;
   logic               rsp_ff, rsp_in;

   // Stack memory: one write port, one registered read port.
   logic [WORD_W-1:0]  mem [STACK_DEPTH];
   logic [WORD_W-1:0]  rd_ff;
   logic [SP_W-1:0]    rd_addr;
   logic               wr_en;
   logic [SP_W-1:0]    wr_addr;
   logic [WORD_W-1:0]  wr_data;

   ser_ctl_type          sctl;
   ser_sts_type          ssts;
   logic [2*WORD_W-1:0]  prod;
   logic [WORD_W-1:0]    quot, rem;
   logic [WORD_W-1:0]    a_mag, b_mag;

   logic is_un, is_rd, is_badop, is_ser;
   logic [WORD_W:0] sum_x, dif_x;
   logic signed [WORD_W-1:0] as, bs;
   logic [WORD_W-1:0] alu_res, ser_res;
   logic alu_ov, ser_ov;
   logic mneg, mov;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign a_mag = a_ff[WORD_W-1] ? (~a_ff + 1'b1) : a_ff;
   assign b_mag = b_ff[WORD_W-1] ? (~b_ff + 1'b1) : b_ff;

   smou_serial_unit u_ser (
      .clock (clock), .reset (reset), .ctl (sctl),
      .a_mag (a_mag), .b_mag (b_mag), .sts (ssts),
      .prod (prod), .quot (quot), .rem (rem)
   );

   // Opcode decode and the combinational arithmetic on the fetched operands.
   always_comb begin
      is_badop = (op_ff == 5'd0) || (op_ff > OP_READLN);
      is_rd    = (op_ff == OP_READ) || (op_ff == OP_READLN);
      is_un    = (op_ff == OP_NEG) || (op_ff == OP_WRITE) || (op_ff == OP_WRITELN);
      is_ser   = (op_ff == OP_MUL) || (op_ff == OP_DIV) || (op_ff == OP_MOD);
      as = a_ff;
      bs = b_ff;
      sum_x = {a_ff[WORD_W-1], a_ff} + {b_ff[WORD_W-1], b_ff};
      dif_x = {a_ff[WORD_W-1], a_ff} - {b_ff[WORD_W-1], b_ff};
      alu_ov = 1'b0;
      unique case (op_ff)
         OP_ADD: begin
            alu_res = sum_x[WORD_W-1:0];
            alu_ov = (sum_x[WORD_W] != sum_x[WORD_W-1]);
         end
         OP_SUB: begin
            alu_res = dif_x[WORD_W-1:0];
            alu_ov = (dif_x[WORD_W] != dif_x[WORD_W-1]);
         end
         OP_EQ: alu_res = WORD_W'(as == bs);
         OP_NE: alu_res = WORD_W'(as != bs);
         OP_LT: alu_res = WORD_W'(as < bs);
         OP_GE: alu_res = WORD_W'(as >= bs);
         OP_GT: alu_res = WORD_W'(as > bs);
         default: alu_res = WORD_W'(as <= bs);
      endcase
   end

   // Sign fix-up of the serial unit's magnitudes.
   always_comb begin
      mneg = a_ff[WORD_W-1] ^ b_ff[WORD_W-1];
      // Product fits when the magnitude is below 2^31, or exactly 2^31 if negative.
      mov = (prod[2*WORD_W-1:WORD_W] != '0) ||
            (prod[WORD_W-1] && !(mneg && prod[WORD_W-2:0] == '0));
      ser_ov = 1'b0;
      if (op_ff == OP_MUL) begin
         ser_res = mneg ? (~prod[WORD_W-1:0] + 1'b1) : prod[WORD_W-1:0];
         ser_ov = mov;
      end else if (op_ff == OP_DIV) begin
         ser_res = mneg ? (~quot + 1'b1) : quot;
         // The most negative value divided by -1 has no 32-bit quotient.
         ser_ov = (a_ff == {1'b1, {(WORD_W-1){1'b0}}}) && (b_ff == '1);
      end else begin
         // The remainder takes the sign of the dividend.
         ser_res = a_ff[WORD_W-1] ? (~rem + 1'b1) : rem;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      op_in = op_ff; sflag_in = sflag_ff; rval_in = rval_ff;
      a_in = a_ff; b_in = b_ff; st_in = st_ff;
      pv_in = pv_ff; pval_in = pval_ff; pstr_in = pstr_ff; pnl_in = pnl_ff;
      rsp_in = 1'b0;
      rd_addr = SP_W'(cnt_ff - 1'b1);
      wr_en = 1'b0;
      wr_addr = SP_W'(cnt_ff - 2'd2);
      wr_data = alu_res;
      sctl.start = 1'b0;
      sctl.is_mul = (op_ff == OP_MUL);
      unique case (state_ff)
         S_IDLE: begin
            // The read of the top word is already under way here.
            if (start) begin
               op_in = req_opcode; sflag_in = req_string_flag;
               rval_in = req_read_value;
               st_in = ST_OK; pv_in = 1'b0; pval_in = '0;
               pstr_in = 1'b0; pnl_in = 1'b0;
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            b_in = rd_ff;
            rd_addr = SP_W'(cnt_ff - 2'd2);
            state_in = S_RDA;
         end
         S_RDA: begin
            a_in = rd_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_TOP;
            if (is_badop) begin
               st_in = ST_BADOP;
            end else if (is_rd) begin
               if (cnt_ff >= CNT_W'(STACK_DEPTH)) begin
                  st_in = ST_SOVF;
               end else begin
                  wr_en = 1'b1;
                  wr_addr = SP_W'(cnt_ff);
                  wr_data = rval_ff;
                  cnt_in = cnt_ff + 1'b1;
               end
            end else if (is_un) begin
               if (cnt_ff == '0) begin
                  st_in = ST_UNDER;
               end else if (op_ff == OP_NEG) begin
                  // Negating the most negative value wraps to itself.
                  wr_en = 1'b1;
                  wr_addr = SP_W'(cnt_ff - 1'b1);
                  wr_data = ~b_ff + 1'b1;
               end else begin
                  pv_in = 1'b1; pval_in = b_ff; pstr_in = sflag_ff;
                  pnl_in = (op_ff == OP_WRITELN);
                  cnt_in = cnt_ff - 1'b1;
               end
            end else if (cnt_ff < CNT_W'(2)) begin
               st_in = ST_UNDER;
            end else if (is_ser) begin
               if (op_ff != OP_MUL && b_ff == '0) begin
                  st_in = ST_DIV0;
               end else begin
                  sctl.start = 1'b1;
                  state_in = S_SER;
               end
            end else if (alu_ov) begin
               st_in = ST_AOVF;
            end else begin
               wr_en = 1'b1;
               wr_data = alu_res;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_SER: begin
            // Wait for the serial unit; its outputs hold once done rises.
            if (ssts.done) begin
               state_in = S_TOP;
               if (ser_ov) begin
                  st_in = ST_AOVF;
               end else begin
                  wr_en = 1'b1;
                  wr_data = ser_res;
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         S_TOP: begin
            // The read of the new top word lands in rd_ff for the response.
            rsp_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_ff <= rsp_in;
      end
      op_ff <= op_in; sflag_ff <= sflag_in; rval_ff <= rval_in;
      a_ff <= a_in; b_ff <= b_in; st_ff <= st_in;
      pv_ff <= pv_in; pval_ff <= pval_in; pstr_ff <= pstr_in; pnl_ff <= pnl_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_ff;
   assign rsp_status = st_ff;
   assign rsp_print_valid = pv_ff;
   assign rsp_print_value = pval_ff;
   assign rsp_print_is_string = pstr_ff;
   assign rsp_print_newline = pnl_ff;
   assign rsp_top_value = (cnt_ff == '0) ? '0 : rd_ff;
   assign rsp_stack_count = 9'(cnt_ff);

`ifndef NO_ASSERTIONS
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STACK_DEPTH)) else $error("stack count out of range");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response held two cycles");
`endif

endmodule
